### sv/cubic_bezier_sampler_macros.svh
// Assertion macros for the cubic Bezier sampler.
`ifndef CUBIC_BEZIER_SAMPLER_MACROS_SVH
`define CUBIC_BEZIER_SAMPLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBS_ASSERT(lbl, prop, msg)
`define CBS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### sv/cbs_pkg.sv
// Shared types and constants for the cubic Bezier sampler.
package cbs_pkg;
  localparam int IDX_W = 6;
  localparam int T_W = 17;
  localparam int NPTS = 12;
  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_COORD_WIDTH = 16;
  localparam logic [IDX_W-1:0] SEG_RESET = 6'd16;
  localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic vld;
    logic [T_W-1:0] t;
    logic [IDX_W-1:0] idx;
    logic last;
  } sample_ctl_t;
endpackage

### sv/cbs_front.sv
// Front end: segment register, item accept, segment count clamp and word queue.
module cbs_front #(
  parameter int MAX_SAMPLES = 64,
  parameter int CW = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [cbs_pkg::IDX_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [cbs_pkg::NPTS-1:0][CW-1:0] in_pts,
  input  logic pop,
  output logic q_ne,
  output logic [cbs_pkg::NPTS-1:0][CW-1:0] q_pts,
  output logic [cbs_pkg::IDX_W-1:0] q_n
);
  import cbs_pkg::*;

  localparam logic [IDX_W-1:0] NMAX = IDX_W'(MAX_SAMPLES - 1);

  logic [IDX_W-1:0] segments;
  logic [IDX_W-1:0] n_eff;
  logic [NPTS-1:0][CW-1:0] qpts [2];
  logic [IDX_W-1:0] qn [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push;

  assign push = in_valid && !in_stall;
  assign in_stall = cnt[1];
  assign q_ne = cnt != 2'd0;
  assign q_pts = qpts[rp];
  assign q_n = qn[rp];

  always_comb begin
    n_eff = (segments == '0) ? IDX_W'(1) : segments;
    if (n_eff > NMAX) n_eff = NMAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= SEG_RESET;
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (cfg_we) segments <= cfg_data;
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      qpts[wp] <= in_pts;
      qn[wp] <= n_eff;
    end
  end
endmodule

### sv/cbs_seq.sv
// Back-end sequencer: step divider for 1/N and the per-sample t generator.
module cbs_seq #(
  parameter int CW = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_ne,
  input  logic [cbs_pkg::NPTS-1:0][CW-1:0] q_pts,
  input  logic [cbs_pkg::IDX_W-1:0] q_n,
  output logic pop,
  input  logic adv,
  output cbs_pkg::sample_ctl_t ctl,
  output logic [cbs_pkg::NPTS-1:0][CW-1:0] pts
);
  import cbs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_RUN = 2'd2;

  logic [1:0] state;
  logic [IDX_W-1:0] n, i;
  logic [4:0] cnt;
  logic [IDX_W:0] rem, rem_sh, rem_next;
  logic [T_W-1:0] quo, quo_next;
  logic [T_W-1:0] qstep, tq;
  logic [IDX_W-1:0] rstep, r;
  logic [IDX_W:0] r2;
  logic is_last;

  assign pop = (state == S_IDLE) && q_ne;
  assign is_last = i == n;

  always_comb begin
    rem_sh = {rem[IDX_W-1:0], (cnt == 5'd16)};
    quo_next = {quo[T_W-2:0], 1'b0};
    rem_next = rem_sh;
    if (rem_sh >= {1'b0, n}) begin
      rem_next = rem_sh - {1'b0, n};
      quo_next[0] = 1'b1;
    end
    r2 = {1'b0, r} + {1'b0, rstep};
  end

  always_comb begin
    ctl.vld = (state == S_RUN) && adv;
    ctl.t = (tq > ONE_Q16) ? ONE_Q16 : tq;
    ctl.idx = i;
    ctl.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (q_ne) state <= S_DIV;
        S_DIV: if (cnt == 5'd0) state <= S_RUN;
        S_RUN: if (adv && is_last) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
    case (state)
      S_IDLE: begin
        pts <= q_pts;
        n <= q_n;
        rem <= '0;
        quo <= '0;
        cnt <= 5'd16;
      end
      S_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          qstep <= quo_next;
          rstep <= rem_next[IDX_W-1:0];
          i <= '0;
          tq <= '0;
          r <= n >> 1;
        end
      end
      S_RUN: begin
        if (adv) begin
          i <= i + IDX_W'(1);
          if (r2 >= {1'b0, n}) begin
            r <= IDX_W'(r2 - {1'b0, n});
            tq <= tq + qstep + T_W'(1);
          end else begin
            r <= r2[IDX_W-1:0];
            tq <= tq + qstep;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

### sv/cbs_eval.sv
// Back-end evaluator: Bernstein weights and weighted blend, five stages.
module cbs_eval #(
  parameter int CW = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  cbs_pkg::sample_ctl_t ctl,
  input  logic [cbs_pkg::NPTS-1:0][CW-1:0] pts,
  output logic out_valid,
  output logic [2:0][CW-1:0] curve,
  output logic [cbs_pkg::IDX_W-1:0] idx,
  output logic last
);
  import cbs_pkg::*;

  localparam int HW = CW + 25;
  localparam int LW = CW + 24;
  localparam int SW = CW + 50;
  localparam logic [CW-1:0] SGN = {1'b1, {(CW-1){1'b0}}};

  sample_ctl_t c1, c2, c3, c4;
  logic [NPTS-1:0][CW-1:0] p1, p2;
  logic [T_W-1:0] u0, u1, t1;
  logic [33:0] uu, tt;
  logic [50:0] m0, m1, m2, m3;
  logic [3:0][48:0] w;
  logic [2:0][3:0][HW-1:0] ph;
  logic [2:0][3:0][LW-1:0] pl;
  logic [2:0][HW+1:0] sh;
  logic [2:0][LW+1:0] sl;
  logic [2:0][SW-1:0] s;

  assign u0 = ONE_Q16 - ctl.t;
  assign m0 = 51'(uu) * 51'(u1);
  assign m1 = 51'(uu) * 51'(t1);
  assign m2 = 51'(tt) * 51'(u1);
  assign m3 = 51'(tt) * 51'(t1);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s[a] = (SW'(sh[a]) << 24) + SW'(sl[a]) + (SW'(1) << 47);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld <= 1'b0;
      c2.vld <= 1'b0;
      c3.vld <= 1'b0;
      c4.vld <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c1.vld <= ctl.vld;
      c2.vld <= c1.vld;
      c3.vld <= c2.vld;
      c4.vld <= c3.vld;
      out_valid <= c4.vld;
    end
    if (adv) begin
      {c1.t, c1.idx, c1.last} <= {ctl.t, ctl.idx, ctl.last};
      {c2.t, c2.idx, c2.last} <= {c1.t, c1.idx, c1.last};
      {c3.t, c3.idx, c3.last} <= {c2.t, c2.idx, c2.last};
      {c4.t, c4.idx, c4.last} <= {c3.t, c3.idx, c3.last};
      p1 <= pts;
      p2 <= p1;
      u1 <= u0;
      t1 <= ctl.t;
      uu <= 34'(u0) * 34'(u0);
      tt <= 34'(ctl.t) * 34'(ctl.t);
      w[0] <= m0[48:0];
      w[1] <= m1[48:0] + {m1[47:0], 1'b0};
      w[2] <= m2[48:0] + {m2[47:0], 1'b0};
      w[3] <= m3[48:0];
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 4; k++) begin
          ph[a][k] <= HW'(p2[k*3+a] ^ SGN) * HW'(w[k][48:24]);
          pl[a][k] <= LW'(p2[k*3+a] ^ SGN) * LW'(w[k][23:0]);
        end
        sh[a] <= (HW+2)'(ph[a][0]) + (HW+2)'(ph[a][1]) + (HW+2)'(ph[a][2])
                 + (HW+2)'(ph[a][3]);
        sl[a] <= (LW+2)'(pl[a][0]) + (LW+2)'(pl[a][1]) + (LW+2)'(pl[a][2])
                 + (LW+2)'(pl[a][3]);
        curve[a] <= {~s[a][CW+47], s[a][CW+46:48]};
      end
      idx <= c4.idx;
      last <= c4.last;
    end
  end
endmodule

### sv/cubic_bezier_sampler.sv
// Cubic Bezier sampler: one word of four 3D control points in, N+1 curve points
// out at t = i/N, one point per cycle while the output is not stalled. Each
// word needs setup (a bit-serial divide of 1.0 by N in the sequencer) before
// its samples; a two-word queue lets the next word be accepted during a run.
// The first point leaves through the weight and blend pipeline. Segment count
// 0 runs as 1 and is capped at MAX_SAMPLES-1.
module cubic_bezier_sampler #(
  parameter int MAX_SAMPLES = cbs_pkg::DEF_MAX_SAMPLES,
  parameter int COORD_WIDTH = cbs_pkg::DEF_COORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [cbs_pkg::IDX_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COORD_WIDTH-1:0] p0_x,
  input  logic signed [COORD_WIDTH-1:0] p0_y,
  input  logic signed [COORD_WIDTH-1:0] p0_z,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p1_z,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p2_z,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  input  logic signed [COORD_WIDTH-1:0] p3_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [COORD_WIDTH-1:0] curve_x,
  output logic signed [COORD_WIDTH-1:0] curve_y,
  output logic signed [COORD_WIDTH-1:0] curve_z,
  output logic [cbs_pkg::IDX_W-1:0] sample_index,
  output logic last
);
  import cbs_pkg::*;
  `include "cubic_bezier_sampler_macros.svh"

  logic [NPTS-1:0][COORD_WIDTH-1:0] in_pts, q_pts, pts;
  logic [IDX_W-1:0] q_n;
  logic q_ne, pop, adv;
  sample_ctl_t ctl;
  logic [2:0][COORD_WIDTH-1:0] curve;

  assign in_pts = {p3_z, p3_y, p3_x, p2_z, p2_y, p2_x, p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};
  assign adv = !out_valid || !out_stall;
  assign curve_x = curve[0];
  assign curve_y = curve[1];
  assign curve_z = curve[2];

  cbs_front #(.MAX_SAMPLES(MAX_SAMPLES), .CW(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_pts(in_pts),
    .pop(pop), .q_ne(q_ne), .q_pts(q_pts), .q_n(q_n)
  );

  cbs_seq #(.CW(COORD_WIDTH)) u_seq (
    .clk(clk), .rst(rst), .q_ne(q_ne), .q_pts(q_pts), .q_n(q_n),
    .pop(pop), .adv(adv), .ctl(ctl), .pts(pts)
  );

  cbs_eval #(.CW(COORD_WIDTH)) u_eval (
    .clk(clk), .rst(rst), .adv(adv), .ctl(ctl), .pts(pts),
    .out_valid(out_valid), .curve(curve), .idx(sample_index), .last(last)
  );

  `CBS_ASSERT(a_last_not_first, out_valid && last |-> sample_index != '0, "last on first sample")
  `CBS_ASSERT(a_issue_adv, ctl.vld |-> adv, "sample issued into stalled pipeline")
  `CBS_ASSERT(a_pop_ne, pop |-> q_ne, "queue popped while empty")
  `CBS_ASSERT_RST(a_rst_idle, rst |=> !out_valid, "output valid after reset")
endmodule
